@@ rtl/core/imuavg_pkg.sv @@
// shared types, constants and tables of the imu attitude and acceleration average block
package imuavg_pkg;

  localparam int WINDOW_LEN_DEF   = 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int DATA_W           = 16;
  localparam int SAMPLE_W         = 7 * DATA_W;
  localparam int IN_TDATA_W       = 10 * DATA_W;
  localparam int OUT_TDATA_W      = 96;
  localparam int CFG_W            = 5;
  localparam int PHASE_W          = 4;
  localparam int CNT_W            = 5;
  localparam int QUEUE_DEPTH      = 2;
  localparam int YAW_LIMIT        = 18000;
  localparam int TILT_LIMIT       = 9000;

  localparam logic [CFG_W-1:0] DEC_RESET = 5'd2;
  localparam logic [CFG_W-1:0] DEC_MAX   = 5'd16;
  localparam logic [31:0]      HALF_TURN = 32'd1179648000;

  typedef struct packed {
    logic signed [DATA_W-1:0] gz;
    logic signed [DATA_W-1:0] gy;
    logic signed [DATA_W-1:0] gx;
    logic signed [DATA_W-1:0] qz;
    logic signed [DATA_W-1:0] qy;
    logic signed [DATA_W-1:0] qx;
    logic signed [DATA_W-1:0] qw;
  } sample_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_UPD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SQRT,
    B_LOAD,
    B_NORM,
    B_ROT,
    B_ROUND,
    B_EMIT
  } back_state_t;

  function automatic logic [31:0] atan_val(input logic [CNT_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'd294912000;
      5'd1:    v = 32'd174096719;
      5'd2:    v = 32'd91987925;
      5'd3:    v = 32'd46694507;
      5'd4:    v = 32'd23437865;
      5'd5:    v = 32'd11730358;
      5'd6:    v = 32'd5866610;
      5'd7:    v = 32'd2933484;
      5'd8:    v = 32'd1466764;
      5'd9:    v = 32'd733385;
      5'd10:   v = 32'd366693;
      5'd11:   v = 32'd183346;
      5'd12:   v = 32'd91673;
      5'd13:   v = 32'd45837;
      5'd14:   v = 32'd22918;
      5'd15:   v = 32'd11459;
      5'd16:   v = 32'd5730;
      5'd17:   v = 32'd2865;
      5'd18:   v = 32'd1432;
      5'd19:   v = 32'd716;
      5'd20:   v = 32'd358;
      5'd21:   v = 32'd179;
      5'd22:   v = 32'd90;
      5'd23:   v = 32'd45;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/imu_attitude_and_accel_average.sv @@
// top level of the imu attitude and acceleration average block
//
//  channel | dir | handshake                  | payload
//  in      | in  | in_tvalid / in_tready      | in_tdata, 160 bits
//  out     | out | out_tvalid / out_tready    | out_tdata, 96 bits
//  cfg     | in  | cfg_valid / cfg_ready      | cfg_data, decimation ratio
//
// the front takes one sample at a time and waits for room in the job queue when a job is due
// an emitted result passes through the back in order: taking the job, products and window means,
// the paired square roots, then per angle a load, normalize, CORDIC_STEPS rotations and
// rounding on the one shared cordic unit, with the load going straight to rounding when both
// operands are zero, and last the load of the output register
// samples that emit nothing cost only the front cycles
// reset clears control, window fill and sums; no clearing pass
// out_tvalid holds the result until taken while the back works on the next job
module imu_attitude_and_accel_average #(
  parameter int WINDOW_LEN   = imuavg_pkg::WINDOW_LEN_DEF,
  parameter int CORDIC_STEPS = imuavg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // quat_w, quat_x, quat_y, quat_z, grav_x, grav_y, grav_z, lin_acc_x, lin_acc_y, lin_acc_z
  input  logic [imuavg_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // yaw_angle, pitch_angle, roll_angle, mean_acc_x, mean_acc_y, mean_acc_z, zero pad
  output logic [imuavg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [imuavg_pkg::CFG_W-1:0]        cfg_data
);
  import imuavg_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);
  localparam int JOB_W = SAMPLE_W + 3 * SUM_W;

  logic [CFG_W-1:0] ratio_r;
  logic             f_valid, f_ready, b_valid, b_ready;
  logic [JOB_W-1:0] f_data, b_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= DEC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ratio_r <= cfg_data;
    end
  end

  imuavg_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ratio     (ratio_r),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_data  (f_data)
  );

  imuavg_fifo #(
    .W (JOB_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  imuavg_back #(
    .WINDOW_LEN   (WINDOW_LEN),
    .CORDIC_STEPS (CORDIC_STEPS),
    .JOB_W        (JOB_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (b_valid),
    .job_ready  (b_ready),
    .job_data   (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ rtl/core/imuavg_front.sv @@
// front part: accepts samples, keeps the acceleration window and decimation, issues jobs
module imuavg_front #(
  parameter int WINDOW_LEN = imuavg_pkg::WINDOW_LEN_DEF,
  parameter int JOB_W      = imuavg_pkg::SAMPLE_W + 3 * (16 + $clog2(WINDOW_LEN))
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [imuavg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [imuavg_pkg::CFG_W-1:0]       ratio,
  output logic                               job_valid,
  input  logic                               job_ready,
  output logic [JOB_W-1:0]                   job_data
);
  import imuavg_pkg::*;

  localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN);
  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int ACC_W  = 3 * DATA_W;

  front_state_t state_r, state_nxt;

  logic [IN_TDATA_W-1:0]   item_r;
  logic [ACC_W-1:0]        ring [WINDOW_LEN];
  logic [ACC_W-1:0]        ring_rd_r;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [SUM_W-1:0] sum_nxt [3];
  logic [JOB_W-1:0]        job_r;
  logic [CFG_W-1:0]        ratio_eff;
  logic [CFG_W-1:0]        phase_inc;
  logic                    full;
  logic                    emit;

  always_comb begin
    full = (fill_r == FILL_W'(WINDOW_LEN));
    fill_nxt = full ? fill_r : fill_r + FILL_W'(1);
    slot_nxt = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
    priority if (ratio == '0) begin
      ratio_eff = CFG_W'(1);
    end else if (ratio > DEC_MAX) begin
      ratio_eff = DEC_MAX;
    end else begin
      ratio_eff = ratio;
    end
    phase_inc = {1'b0, phase_r} + CFG_W'(1);
    phase_nxt = (phase_inc >= ratio_eff) ? '0 : phase_inc[PHASE_W-1:0];
    emit = (fill_nxt == FILL_W'(WINDOW_LEN)) && (phase_r == '0);
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = sum_r[k]
                 + SUM_W'($signed(item_r[(7 + k) * DATA_W +: DATA_W]))
                 - (full ? SUM_W'($signed(ring_rd_r[k * DATA_W +: DATA_W])) : '0);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_tvalid) state_nxt = F_UPD;
      F_UPD:   state_nxt = emit ? F_PUSH : F_IDLE;
      F_PUSH:  if (job_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == F_IDLE);
    job_valid = (state_r == F_PUSH);
    job_data  = job_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= '0;
      fill_r  <= '0;
      phase_r <= '0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_UPD) begin
        slot_r  <= slot_nxt;
        fill_r  <= fill_nxt;
        phase_r <= phase_nxt;
        for (int k = 0; k < 3; k++) sum_r[k] <= sum_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) item_r <= in_tdata;
    if (state_r == F_UPD) begin
      ring[slot_r] <= item_r[SAMPLE_W +: ACC_W];
      job_r <= {sum_nxt[2], sum_nxt[1], sum_nxt[0], item_r[SAMPLE_W-1:0]};
    end
    ring_rd_r <= ring[slot_r];
  end

endmodule

@@ rtl/core/imuavg_fifo.sv @@
// short job queue between front and back
module imuavg_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import imuavg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_Q-1:0] count_r;
  logic             do_push, do_pop;

  always_comb begin
    push_ready = (count_r != CNT_Q'(QUEUE_DEPTH));
    pop_valid  = (count_r != '0);
    pop_data   = entry_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + CNT_Q'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_Q'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/core/imuavg_back.sv @@
// back part: products, square roots, shared cordic, window mean division, output register
module imuavg_back #(
  parameter int WINDOW_LEN   = imuavg_pkg::WINDOW_LEN_DEF,
  parameter int CORDIC_STEPS = imuavg_pkg::CORDIC_STEPS_DEF,
  parameter int JOB_W        = imuavg_pkg::SAMPLE_W + 3 * (16 + $clog2(WINDOW_LEN))
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               job_valid,
  output logic                               job_ready,
  input  logic [JOB_W-1:0]                   job_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [imuavg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import imuavg_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);
  localparam int CW    = 44;
  localparam int ZW    = 34;
  localparam int SQ_W  = 48;

  // window mean by reciprocal multiplication, exact for magnitudes below 2^SUM_W
  localparam int     DIV_S = SUM_W + $clog2(WINDOW_LEN);
  localparam longint DIV_M = ((longint'(1) << DIV_S) + longint'(WINDOW_LEN) - 1)
                             / longint'(WINDOW_LEN);
  localparam int     M_W   = SUM_W + 2;
  localparam int     P_W   = SUM_W + M_W;
  localparam logic [M_W-1:0] DIV_MUL = M_W'(DIV_M);

  localparam logic [CNT_W-1:0] P_QXQY = 5'd0;
  localparam logic [CNT_W-1:0] P_QZQW = 5'd1;
  localparam logic [CNT_W-1:0] P_QXQX = 5'd2;
  localparam logic [CNT_W-1:0] P_QYQY = 5'd3;
  localparam logic [CNT_W-1:0] P_QZQZ = 5'd4;
  localparam logic [CNT_W-1:0] P_QWQW = 5'd5;
  localparam logic [CNT_W-1:0] P_GXGX = 5'd6;
  localparam logic [CNT_W-1:0] P_GYGY = 5'd7;
  localparam logic [CNT_W-1:0] P_GZGZ = 5'd8;
  localparam logic [CNT_W-1:0] P_DONE = 5'd9;
  localparam logic [CNT_W-1:0] P_SETUP = 5'd10;
  localparam logic [CNT_W-1:0] SQRT_LAST = 5'd23;

  localparam logic [1:0] ANG_YAW   = 2'd0;
  localparam logic [1:0] ANG_PITCH = 2'd1;
  localparam logic [1:0] ANG_ROLL  = 2'd2;

  localparam logic [CW-1:0] NORM_LOW = CW'(1) << 30;
  localparam logic [CW-1:0] NORM_TOP = CW'(1) << 38;

  back_state_t state_r, state_nxt;

  logic [JOB_W-1:0]         job_r;
  sample_t                  smp;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         acc_code;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [31:0]       prod_r;
  logic signed [32:0]       num_r, den_r;
  logic [30:0]              sq_r [3];
  logic [31:0]              s_pitch, s_roll;
  logic [SQ_W-1:0]          sv_r [2];
  logic [SQ_W-1:0]          root_r [2];
  logic [SQ_W-1:0]          bit_r;
  logic [SQ_W-1:0]          sq_t [2];
  logic [SUM_W-1:0]         dv_r [3];
  logic [SUM_W-1:0]         quo_r [3];
  logic                     neg_r [3];
  logic [P_W-1:0]           qprod [3];
  logic signed [SUM_W-1:0]  sum_in [3];
  logic [SUM_W-1:0]         mq [3];
  logic [1:0]               ang_r;
  logic signed [CW-1:0]     cx_r, cy_r, ly, lx;
  logic signed [ZW-1:0]     cz_r, rnd, cd, lim, cl;
  logic [CW-1:0]            abs_x, abs_y, mag;
  logic                     load_zero, norm_done, emit_load, out_tvalid_r;
  logic [DATA_W-1:0]        yaw_r;
  logic [DATA_W-2:0]        pitch_r, roll_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  always_comb begin
    smp = sample_t'(job_r[SAMPLE_W-1:0]);
    acc_code = cnt_r - CNT_W'(1);
    unique case (cnt_r)
      P_QXQY:  begin mul_a = smp.qx; mul_b = smp.qy; end
      P_QZQW:  begin mul_a = smp.qz; mul_b = smp.qw; end
      P_QXQX:  begin mul_a = smp.qx; mul_b = smp.qx; end
      P_QYQY:  begin mul_a = smp.qy; mul_b = smp.qy; end
      P_QZQZ:  begin mul_a = smp.qz; mul_b = smp.qz; end
      P_QWQW:  begin mul_a = smp.qw; mul_b = smp.qw; end
      P_GXGX:  begin mul_a = smp.gx; mul_b = smp.gx; end
      P_GYGY:  begin mul_a = smp.gy; mul_b = smp.gy; end
      P_GZGZ:  begin mul_a = smp.gz; mul_b = smp.gz; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    s_pitch = 32'(sq_r[1]) + 32'(sq_r[2]);
    s_roll  = 32'(sq_r[0]) + 32'(sq_r[2]);
    for (int u = 0; u < 2; u++) sq_t[u] = root_r[u] + bit_r;
    for (int k = 0; k < 3; k++) begin
      sum_in[k] = $signed(job_data[SAMPLE_W + k * SUM_W +: SUM_W]);
      qprod[k] = P_W'(dv_r[k]) * P_W'(DIV_MUL);
      mq[k] = neg_r[k] ? (~quo_r[k] + SUM_W'(1)) : quo_r[k];
    end
    unique case (ang_r)
      ANG_YAW: begin
        ly = CW'(num_r) <<< 1;
        lx = CW'(den_r);
      end
      ANG_PITCH: begin
        ly = CW'(smp.gx) <<< 8;
        lx = CW'({1'b0, root_r[0][23:0]});
      end
      default: begin
        ly = CW'(smp.gy) <<< 8;
        lx = CW'({1'b0, root_r[1][23:0]});
      end
    endcase
    load_zero = (ly == '0) && (lx == '0);
    abs_x = cx_r[CW-1] ? -cx_r : cx_r;
    abs_y = cy_r[CW-1] ? -cy_r : cy_r;
    mag = (abs_x > abs_y) ? abs_x : abs_y;
    norm_done = (mag >= NORM_TOP);
    rnd = cz_r + ZW'(32768);
    cd  = rnd >>> 16;
    lim = (ang_r == ANG_YAW) ? ZW'(YAW_LIMIT) : ZW'(TILT_LIMIT);
    priority if (cd > lim) cl = lim;
    else if (cd < -lim) cl = -lim;
    else cl = cd;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (job_valid) state_nxt = B_MUL;
      B_MUL:   if (cnt_r == P_SETUP) state_nxt = B_SQRT;
      B_SQRT:  if (cnt_r == SQRT_LAST) state_nxt = B_LOAD;
      B_LOAD:  state_nxt = load_zero ? B_ROUND : B_NORM;
      B_NORM:  if (norm_done) state_nxt = B_ROT;
      B_ROT:   if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = B_ROUND;
      B_ROUND: state_nxt = (ang_r == ANG_ROLL) ? B_EMIT : B_LOAD;
      B_EMIT:  if (!out_tvalid_r || out_tready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready  = (state_r == B_IDLE);
    emit_load  = (state_r == B_EMIT) && (!out_tvalid_r || out_tready);
    out_tvalid = out_tvalid_r;
    out_tdata  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_r <= job_data;
          cnt_r <= '0;
          num_r <= '0;
          den_r <= '0;
          for (int k = 0; k < 3; k++) begin
            sq_r[k]  <= '0;
            neg_r[k] <= sum_in[k][SUM_W-1];
            dv_r[k]  <= sum_in[k][SUM_W-1] ? -sum_in[k] : sum_in[k];
          end
        end
      end
      B_MUL: begin
        if (cnt_r < P_DONE) prod_r <= mul_a * mul_b;
        if (cnt_r != '0 && cnt_r <= P_DONE) begin
          unique case (acc_code)
            P_QXQY, P_QZQW: num_r <= num_r + 33'(prod_r);
            P_QXQX, P_QWQW: den_r <= den_r + 33'(prod_r);
            P_QYQY, P_QZQZ: den_r <= den_r - 33'(prod_r);
            P_GXGX:         sq_r[0] <= prod_r[30:0];
            P_GYGY:         sq_r[1] <= prod_r[30:0];
            P_GZGZ:         sq_r[2] <= prod_r[30:0];
            default: ;
          endcase
        end
        if (cnt_r == P_SETUP) begin
          sv_r[0]   <= {s_pitch, 16'h0000};
          sv_r[1]   <= {s_roll, 16'h0000};
          root_r[0] <= '0;
          root_r[1] <= '0;
          bit_r     <= SQ_W'(1) << (SQ_W - 2);
          for (int k = 0; k < 3; k++) quo_r[k] <= SUM_W'(qprod[k] >> DIV_S);
          cnt_r     <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      B_SQRT: begin
        for (int u = 0; u < 2; u++) begin
          if (sv_r[u] >= sq_t[u]) begin
            sv_r[u]   <= sv_r[u] - sq_t[u];
            root_r[u] <= (root_r[u] >> 1) + bit_r;
          end else begin
            root_r[u] <= root_r[u] >> 1;
          end
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + CNT_W'(1);
        ang_r <= ANG_YAW;
      end
      B_LOAD: begin
        if (!load_zero && lx[CW-1]) begin
          cx_r <= -lx;
          cy_r <= -ly;
          cz_r <= ly[CW-1] ? -ZW'(HALF_TURN) : ZW'(HALF_TURN);
        end else begin
          cx_r <= lx;
          cy_r <= ly;
          cz_r <= '0;
        end
      end
      B_NORM: begin
        if (mag < NORM_LOW) begin
          cx_r <= cx_r <<< 8;
          cy_r <= cy_r <<< 8;
        end else if (!norm_done) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
        cnt_r <= '0;
      end
      B_ROT: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + (cy_r >>> cnt_r);
          cy_r <= cy_r - (cx_r >>> cnt_r);
          cz_r <= cz_r + $signed(ZW'(atan_val(cnt_r)));
        end else begin
          cx_r <= cx_r - (cy_r >>> cnt_r);
          cy_r <= cy_r + (cx_r >>> cnt_r);
          cz_r <= cz_r - $signed(ZW'(atan_val(cnt_r)));
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
      B_ROUND: begin
        unique case (ang_r)
          ANG_YAW:   yaw_r <= cl[DATA_W-1:0];
          ANG_PITCH: pitch_r <= cl[DATA_W-2:0];
          default:   roll_r <= cl[DATA_W-2:0];
        endcase
        ang_r <= ang_r + 2'd1;
      end
      B_EMIT: begin
        if (emit_load) begin
          out_data_r <= {2'b00, mq[2][DATA_W-1:0], mq[1][DATA_W-1:0], mq[0][DATA_W-1:0],
                         roll_r, pitch_r, yaw_r};
        end
      end
      default: ;
    endcase
  end

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> ($signed(out_data_r[15:0]) <= 18000 && $signed(out_data_r[15:0]) >= -18000))
    else $error("yaw out of range");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> ($signed(out_data_r[30:16]) <= 9000 && $signed(out_data_r[30:16]) >= -9000
                   && $signed(out_data_r[45:31]) <= 9000 && $signed(out_data_r[45:31]) >= -9000))
    else $error("tilt out of range");

  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROT) |-> (cnt_r < CNT_W'(CORDIC_STEPS)))
    else $error("cordic step count overrun");

  a_job_start: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready) |=> (state_r == B_MUL && cnt_r == '0))
    else $error("job taken without starting products");

endmodule
